// ----- rtl/core/rgb_to_hsv_converter_unit_assert.svh -----
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RHC_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhc: implication check failed");

// implication after a fixed number of cycles
`define RHC_ASSERT_DLY(name, ante, n, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("rhc: delayed check failed");

`endif

// ----- rtl/core/rhc_pkg.sv -----
package rhc_pkg;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned HUE_W      = 15;
	localparam int unsigned NUM_W      = 11;
	localparam int unsigned QUO_W      = 15;
	localparam int unsigned DIVIDEND_W = QUO_W + CHAN_W;
	localparam int unsigned LATENCY    = 3 + QUO_W;
	localparam logic [HUE_W-1:0] HUE_MAX = 15'd23039;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_t;

	// one restoring-division lane: partial remainder, dividend bits left, quotient so far
	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [QUO_W-1:0]  low;
		logic [QUO_W-1:0]  quo;
		logic [CHAN_W-1:0] dvs;
	} div_lane_t;

	typedef struct packed {
		logic              valid;
		div_lane_t         hue;
		div_lane_t         sat;
		logic [CHAN_W-1:0] brightness;
	} div_in_t;

	function automatic div_lane_t div_step(div_lane_t a);
		logic [CHAN_W:0] trial;
		logic            qbit;
		div_lane_t       r;
		trial = {a.rem, a.low[QUO_W-1]};
		qbit  = (trial >= {1'b0, a.dvs});
		r     = a;
		r.rem = qbit ? CHAN_W'(trial - {1'b0, a.dvs}) : trial[CHAN_W-1:0];
		r.low = {a.low[QUO_W-2:0], 1'b0};
		r.quo = {a.quo[QUO_W-2:0], qbit};
		return r;
	endfunction

endpackage

// ----- rtl/core/rhc_div_pipe.sv -----
module rhc_div_pipe
	import rhc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  div_in_t din,
	output logic    done,
	output hsv_t    result
);

	logic              valid_s  [QUO_W];
	div_lane_t         hue_s    [QUO_W];
	div_lane_t         sat_s    [QUO_W];
	logic [CHAN_W-1:0] bright_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i] <= 1'b0;
				end else begin
					valid_s[i] <= din.valid;
				end
			end
			always_ff @(posedge clk) begin
				hue_s[i]    <= div_step(din.hue);
				sat_s[i]    <= div_step(din.sat);
				bright_s[i] <= din.brightness;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i] <= 1'b0;
				end else begin
					valid_s[i] <= valid_s[i-1];
				end
			end
			always_ff @(posedge clk) begin
				hue_s[i]    <= div_step(hue_s[i-1]);
				sat_s[i]    <= div_step(sat_s[i-1]);
				bright_s[i] <= bright_s[i-1];
			end
		end
	end

	assign done              = valid_s[QUO_W-1];
	assign result.hue        = hue_s[QUO_W-1].quo[HUE_W-1:0];
	assign result.saturation = sat_s[QUO_W-1].quo[CHAN_W-1:0];
	assign result.brightness = bright_s[QUO_W-1];

endmodule

// ----- rtl/core/rgb_to_hsv_converter_unit.sv -----
// RGB to HSV converter, fully pipelined.
// Path from the start transfer to done: registers s1, s2 and s3, then the divider stages.
// Throughput: one pixel per cycle; busy is always low, the 15-stage divider sets the depth.
// Reset: arst_n clears all valid bits; data registers are not reset.
// The receiver cannot stall: each result is on the ports for one cycle.
module rgb_to_hsv_converter_unit
	import rhc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pixel_t pixel,
	output logic   done,
	output hsv_t   result
);

	`include "rgb_to_hsv_converter_unit_assert.svh"

	logic              valid_s1;
	pixel_t            pix_s1;

	logic              valid_s2;
	logic [CHAN_W-1:0] mx_s2;
	logic [CHAN_W-1:0] delta_s2;
	logic [NUM_W-1:0]  num_s2;

	logic              valid_s3;
	div_lane_t         hue_s3;
	div_lane_t         sat_s3;
	logic [CHAN_W-1:0] bright_s3;
	div_in_t           din_s3;

	logic [CHAN_W-1:0] mx_c;
	logic [CHAN_W-1:0] mn_c;
	logic [CHAN_W-1:0] delta_c;
	logic [NUM_W-1:0]  delta_w;
	logic [NUM_W-1:0]  num_c;
	logic [DIVIDEND_W-1:0] hue_n;
	logic [DIVIDEND_W-1:0] sat_n;

	assign busy = 1'b0;

	always_comb begin
		mx_c = (pix_s1.red > pix_s1.green) ? pix_s1.red : pix_s1.green;
		mn_c = (pix_s1.red < pix_s1.green) ? pix_s1.red : pix_s1.green;
		if (pix_s1.blue > mx_c) begin
			mx_c = pix_s1.blue;
		end
		if (pix_s1.blue < mn_c) begin
			mn_c = pix_s1.blue;
		end
		delta_c = mx_c - mn_c;
		delta_w = {3'b000, delta_c};
		// sector offset plus signed difference, exact modulo 2^11 since the sum is in range
		priority if (pix_s1.red >= mx_c) begin
			num_c = ((pix_s1.green >= pix_s1.blue) ? '0 : ((delta_w << 2) + (delta_w << 1)))
				+ {3'b000, pix_s1.green} - {3'b000, pix_s1.blue};
		end else if (pix_s1.green >= mx_c) begin
			num_c = (delta_w << 1) + {3'b000, pix_s1.blue} - {3'b000, pix_s1.red};
		end else begin
			num_c = (delta_w << 2) + {3'b000, pix_s1.red} - {3'b000, pix_s1.green};
		end
	end

	// num*3840 and delta*255 by shift and subtract
	assign hue_n = {num_s2, 12'b0} - {4'b0, num_s2, 8'b0};
	assign sat_n = {7'b0, delta_s2, 8'b0} - {15'b0, delta_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1   <= pixel;
		mx_s2    <= mx_c;
		delta_s2 <= delta_c;
		num_s2   <= num_c;

		hue_s3.rem <= hue_n[DIVIDEND_W-1:QUO_W];
		hue_s3.low <= hue_n[QUO_W-1:0];
		hue_s3.quo <= '0;
		hue_s3.dvs <= (delta_s2 == '0) ? CHAN_W'(1) : delta_s2;
		sat_s3.rem <= sat_n[DIVIDEND_W-1:QUO_W];
		sat_s3.low <= sat_n[QUO_W-1:0];
		sat_s3.quo <= '0;
		sat_s3.dvs <= (mx_s2 == '0) ? CHAN_W'(1) : mx_s2;
		bright_s3  <= mx_s2;
	end

	assign din_s3 = '{valid: valid_s3, hue: hue_s3, sat: sat_s3, brightness: bright_s3};

	rhc_div_pipe u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_s3),
		.done   (done),
		.result (result)
	);

	`RHC_ASSERT_IMP(a_hue_range, done, result.hue <= HUE_MAX)
	`RHC_ASSERT_IMP(a_black_zero, done && (result.brightness == '0), result == '0)
	`RHC_ASSERT_DLY(a_latency, start && !busy, LATENCY, done)
	`RHC_ASSERT_IMP(a_no_spurious, done, $past(start, LATENCY))

endmodule

// ----- test/testbench.sv -----
import rhc_pkg::*;

class hsv_checker;
	localparam int unsigned SECTOR_UNITS = 3840;

	hsv_t        expected_hsv[$];
	int unsigned pixels_in;
	int unsigned grey_pixels;
	int unsigned results_checked;
	int unsigned mismatches;

	function new();
		pixels_in       = 0;
		grey_pixels     = 0;
		results_checked = 0;
		mismatches      = 0;
	endfunction

	function hsv_t predict_hsv(pixel_t p);
		int unsigned r, g, b, hi, lo, span, num;
		hsv_t h;
		r  = p.red;
		g  = p.green;
		b  = p.blue;
		hi = (r > g) ? r : g;
		lo = (r < g) ? r : g;
		if (b > hi) hi = b;
		if (b < lo) lo = b;
		span = hi - lo;
		h.brightness = CHAN_W'(hi);
		h.saturation = '0;
		h.hue        = '0;
		if (span != 0) begin
			h.saturation = CHAN_W'((span * 255) / hi);
			// sector pick: red wins ties, then green
			if (r == hi) begin
				num = (g >= b) ? (g - b) : (6 * span - (b - g));
			end else if (g == hi) begin
				num = (2 * span + b) - r;
			end else begin
				num = (4 * span + r) - g;
			end
			h.hue = HUE_W'((num * SECTOR_UNITS) / span);
		end
		return h;
	endfunction

	function void note_pixel(pixel_t p);
		hsv_t h;
		h = predict_hsv(p);
		if (h.saturation == 0) grey_pixels++;
		pixels_in++;
		expected_hsv.push_back(h);
	endfunction

	function void report(string what, hsv_t want, hsv_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
				$realtime, what, want.hue, want.saturation, want.brightness,
				got.hue, got.saturation, got.brightness);
	endfunction

	function void check_hsv(hsv_t got);
		hsv_t want;
		if (expected_hsv.size() == 0) begin
			want = '0;
			report("result with no pixel outstanding", want, got);
			return;
		end
		want = expected_hsv.pop_front();
		results_checked++;
		if (got.hue !== want.hue)
			report("hue mismatch", want, got);
		else if (got.saturation !== want.saturation)
			report("saturation mismatch", want, got);
		else if (got.brightness !== want.brightness)
			report("brightness mismatch", want, got);
	endfunction

	function int unsigned outstanding();
		return expected_hsv.size();
	endfunction
endclass

module testbench;
	localparam int unsigned RANDOM_PIXELS = 1100;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	hsv_t   result;

	hsv_checker sb;

	rgb_to_hsv_converter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_pixel(pixel);
			if (done) sb.check_hsv(result);
		end
	end

	task automatic send_pixel(pixel_t p);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic hold_off(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	function automatic logic [CHAN_W-1:0] near(logic [CHAN_W-1:0] c);
		int v;
		v = int'(c) + $urandom_range(0, 4) - 2;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return CHAN_W'(v);
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [CHAN_W-1:0] c;
		p = pixel_t'($urandom);
		c = CHAN_W'($urandom);
		case ($urandom_range(0, 9))
			4: p = '{c, c, c};
			5: begin
				case ($urandom_range(0, 2))
					0: begin p.green = p.red; if (p.blue > p.red) p.blue = p.red; end
					1: begin p.blue = p.green; if (p.red > p.green) p.red = p.green; end
					default: begin p.blue = p.red; if (p.green > p.red) p.green = p.red; end
				endcase
			end
			6: begin
				p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
				p.green = $urandom_range(0, 1) ? 8'hff : p.green;
				p.blue  = $urandom_range(0, 1) ? 8'h00 : p.blue;
			end
			7: p = '{near(c), near(c), near(c)};
			8: p.blue = 8'hff;
			9: p.green = 8'h00;
			default: ;
		endcase
		return p;
	endfunction

	pixel_t directed_pixels[] = '{
		'{8'h00, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'hff}, '{8'h80, 8'h80, 8'h80},
		'{8'h01, 8'h01, 8'h01}, '{8'hff, 8'h00, 8'h00}, '{8'h00, 8'hff, 8'h00},
		'{8'h00, 8'h00, 8'hff}, '{8'hff, 8'hff, 8'h00}, '{8'h00, 8'hff, 8'hff},
		'{8'hff, 8'h00, 8'hff}, '{8'hc8, 8'h10, 8'h40}, '{8'hc8, 8'h40, 8'h10},
		'{8'h30, 8'hc8, 8'h10}, '{8'h10, 8'hc8, 8'h30}, '{8'h30, 8'h10, 8'hc8},
		'{8'h10, 8'h30, 8'hc8}, '{8'hff, 8'hfe, 8'hfe}, '{8'hfe, 8'hfe, 8'hff},
		'{8'h01, 8'h00, 8'h00}, '{8'h00, 8'h01, 8'h00}, '{8'h00, 8'h00, 8'h01},
		'{8'hff, 8'hfe, 8'hff}, '{8'h01, 8'h00, 8'h01}, '{8'hab, 8'h55, 8'hab}
	};

	initial begin
		int unsigned sent;
		int unsigned burst;
		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		pixel  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
		drain();

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				send_pixel(random_pixel());
				sent++;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: ;
				3: drain();
				default: hold_off($urandom_range(1, 12));
			endcase
		end

		drain();
		repeat (LATENCY + 5) @(posedge clk);
		$display("converted %0d pixels (%0d grey), checked %0d results, %0d mismatches",
			sb.pixels_in, sb.grey_pixels, sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("timed out with %0d results outstanding", sb.outstanding());
		$display("testbench: errors");
		$finish;
	end
endmodule
